### rtl/nnl2_pkg.sv
// Shared types and constants for the nearest-neighbor L2 classifier.
package nnl2_pkg;

  localparam int WEIGHT_W   = 24;
  localparam int LABEL_W    = 16;
  localparam int DIST_W     = 54;
  localparam int SQ_W       = 2 * (WEIGHT_W + 1);
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;
  localparam int ENTRIES_W  = 9;
  localparam int COMPS_W    = 7;

  localparam logic [DIST_W-1:0]     DIST_MAX         = {DIST_W{1'b1}};
  localparam logic [CFG_IDX_W-1:0]  CFG_ENTRIES      = 2'd0;
  localparam logic [CFG_IDX_W-1:0]  CFG_COMPONENTS   = 2'd1;
  localparam logic [COMPS_W-1:0]    COMPS_RESET      = 7'd64;

  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  // Controller to datapath
  typedef struct packed {
    logic accept;   // input transfer this cycle
    logic start;    // final query accepted: clear best, rewind scan
    logic issue;    // issue one scan read
    logic publish;  // load result into the output register
  } nnl2_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic issue_last; // current read is the final one (or nothing to scan)
    logic pipe_busy;  // scan pipeline still holds work
    logic out_held;   // output register holds a result that is stalled
  } nnl2_status_t;

endpackage

### rtl/nnl2_ctrl.sv
// Sequencer for input acceptance, table scan, drain and result hand-off.
module nnl2_ctrl
  import nnl2_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  input  logic         in_func,
  input  logic         in_query_last,
  output logic         in_stall,
  input  nnl2_status_t status,
  output nnl2_cmd_t    cmd
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_DRAIN  = 2'd2;
  localparam logic [1:0] S_RESULT = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  assign in_stall = (state_r != S_IDLE);

  // Next state and commands
  always_comb begin
    state_nxt   = state_r;
    cmd.accept  = 1'b0;
    cmd.start   = 1'b0;
    cmd.issue   = 1'b0;
    cmd.publish = 1'b0;
    case (state_r)
      S_IDLE: begin
        cmd.accept = in_valid;
        if (in_valid && in_func == FUNC_QUERY && in_query_last) begin
          cmd.start = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.issue = 1'b1;
        if (status.issue_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!status.pipe_busy) begin
          state_nxt = S_RESULT;
        end
      end
      S_RESULT: begin
        if (!status.out_held) begin
          cmd.publish = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### rtl/nnl2_datapath.sv
// Reference and query stores, distance pipeline, best tracking and output register.
module nnl2_datapath
  import nnl2_pkg::*;
#(
  parameter int MAX_ENTRIES    = 256,
  parameter int MAX_COMPONENTS = 64
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_func,
  input  logic [7:0]                 in_entry_index,
  input  logic [5:0]                 in_component_index,
  input  logic signed [WEIGHT_W-1:0] in_weight_value,
  input  logic [LABEL_W-1:0]         in_entry_label,
  input  logic                       cfg_wr,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_DATA_W-1:0]      cfg_data,
  input  nnl2_cmd_t                  cmd,
  output nnl2_status_t               status,
  input  logic                       out_stall,
  output logic                       out_valid,
  output logic                       out_match_found,
  output logic [LABEL_W-1:0]         out_best_label,
  output logic [DIST_W-1:0]          out_best_distance_sq
);

  localparam int EIW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int ECW = $clog2(MAX_ENTRIES + 1);
  localparam int CIW = (MAX_COMPONENTS > 1) ? $clog2(MAX_COMPONENTS) : 1;
  localparam int CCW = $clog2(MAX_COMPONENTS + 1);
  localparam int WDEPTH = MAX_ENTRIES * (1 << CIW);

  // Configuration registers
  logic [ENTRIES_W-1:0] entries_r;
  logic [COMPS_W-1:0]   comps_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entries_r <= '0;
      comps_r   <= COMPS_RESET;
    end else if (cfg_wr) begin
      if (cfg_index == CFG_ENTRIES) begin
        entries_r <= cfg_data[ENTRIES_W-1:0];
      end else if (cfg_index == CFG_COMPONENTS) begin
        comps_r <= cfg_data[COMPS_W-1:0];
      end
    end
  end

  // Saturate the counts to the table size
  logic [ECW-1:0] ne_eff;
  logic [CCW-1:0] nc_eff;
  logic           nc_zero;
  logic           table_empty;
  logic [EIW-1:0] last_e;
  logic [CIW-1:0] last_c;

  assign ne_eff = (32'(entries_r) > 32'(MAX_ENTRIES)) ? ECW'(MAX_ENTRIES) : ECW'(entries_r);
  assign nc_eff = (32'(comps_r) > 32'(MAX_COMPONENTS)) ? CCW'(MAX_COMPONENTS) : CCW'(comps_r);
  assign nc_zero     = (nc_eff == '0);
  assign table_empty = (ne_eff == '0);
  assign last_e      = EIW'(32'(ne_eff) - 32'd1);
  assign last_c      = nc_zero ? '0 : CIW'(32'(nc_eff) - 32'd1);

  // Input write decode
  logic           ent_ok;
  logic           comp_ok;
  logic           load_we;
  logic           query_we;
  logic [EIW-1:0] wr_e;
  logic [CIW-1:0] wr_c;

  assign ent_ok   = (32'(in_entry_index) < 32'(MAX_ENTRIES));
  assign comp_ok  = (32'(in_component_index) < 32'(MAX_COMPONENTS));
  assign load_we  = cmd.accept && in_func == FUNC_LOAD && ent_ok && comp_ok;
  assign query_we = cmd.accept && in_func == FUNC_QUERY && comp_ok;
  assign wr_e     = EIW'(in_entry_index);
  assign wr_c     = CIW'(in_component_index);

  // Scan counters
  logic [EIW-1:0] e_r;
  logic [CIW-1:0] c_r;
  logic           issue_v;
  logic           c_wrap;

  assign issue_v = cmd.issue && !table_empty;
  assign c_wrap  = (c_r == last_c);

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      e_r <= '0;
      c_r <= '0;
    end else if (issue_v) begin
      if (c_wrap) begin
        c_r <= '0;
        e_r <= e_r + 1'b1;
      end else begin
        c_r <= c_r + 1'b1;
      end
    end
  end

  // Memories: one write port for input transfers, one registered read for the scan
  logic [WEIGHT_W-1:0] wmem [WDEPTH];
  logic [WEIGHT_W-1:0] qmem [MAX_COMPONENTS];
  logic [LABEL_W-1:0]  lmem [MAX_ENTRIES];
  logic [WEIGHT_W-1:0] w_rd_r;
  logic [WEIGHT_W-1:0] q_rd_r;
  logic [LABEL_W-1:0]  label_rd_r;
  logic [EIW-1:0]      fin_e_r;

  always_ff @(posedge clk) begin
    if (load_we) begin
      wmem[{wr_e, wr_c}] <= in_weight_value;
    end
    w_rd_r <= wmem[{e_r, c_r}];
  end

  always_ff @(posedge clk) begin
    if (query_we) begin
      qmem[wr_c] <= in_weight_value;
    end
    q_rd_r <= qmem[c_r];
  end

  always_ff @(posedge clk) begin
    if (load_we) begin
      lmem[wr_e] <= in_entry_label;
    end
    label_rd_r <= lmem[fin_e_r];
  end

  // Pipeline control tags
  logic           v1_r, v2_r, v3_r, fin_v_r, cmp_v_r;
  logic           first1_r, first2_r, first3_r;
  logic           last1_r, last2_r, last3_r;
  logic [EIW-1:0] e1_r, e2_r, e3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
      v3_r    <= 1'b0;
      fin_v_r <= 1'b0;
      cmp_v_r <= 1'b0;
    end else begin
      v1_r    <= issue_v;
      v2_r    <= v1_r;
      v3_r    <= v2_r;
      fin_v_r <= v3_r && last3_r;
      cmp_v_r <= fin_v_r;
    end
  end

  always_ff @(posedge clk) begin
    first1_r <= (c_r == '0);
    last1_r  <= c_wrap;
    e1_r     <= e_r;
    first2_r <= first1_r;
    last2_r  <= last1_r;
    e2_r     <= e1_r;
    first3_r <= first2_r;
    last3_r  <= last2_r;
    e3_r     <= e2_r;
    fin_e_r  <= e3_r;
  end

  // Difference, square, saturating accumulate
  logic signed [WEIGHT_W:0] diff_r;
  logic [WEIGHT_W:0]        mag;
  logic [SQ_W-1:0]          sq_r;
  logic [DIST_W-1:0]        acc_r;
  logic [DIST_W-1:0]        acc_base;
  logic [DIST_W:0]          acc_sum;
  logic [DIST_W-1:0]        cmp_dist_r;

  assign mag      = diff_r[WEIGHT_W] ? unsigned'(-diff_r) : unsigned'(diff_r);
  assign acc_base = first3_r ? '0 : acc_r;
  assign acc_sum  = {1'b0, acc_base} + (DIST_W + 1)'(sq_r);

  always_ff @(posedge clk) begin
    diff_r <= $signed({w_rd_r[WEIGHT_W-1], w_rd_r}) - $signed({q_rd_r[WEIGHT_W-1], q_rd_r});
    sq_r   <= nc_zero ? '0 : SQ_W'(mag * mag);
    if (v3_r) begin
      acc_r <= (acc_sum > {1'b0, DIST_MAX}) ? DIST_MAX : acc_sum[DIST_W-1:0];
    end
    cmp_dist_r <= acc_r;
  end

  // Best entry so far: strictly smaller wins, so the first of equals is kept
  logic               found_r;
  logic [DIST_W-1:0]  best_r;
  logic [LABEL_W-1:0] win_label_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r     <= 1'b0;
      best_r      <= DIST_MAX;
      win_label_r <= '0;
    end else if (cmd.start) begin
      found_r     <= 1'b0;
      best_r      <= DIST_MAX;
      win_label_r <= '0;
    end else if (cmp_v_r && (!found_r || cmp_dist_r < best_r)) begin
      found_r     <= 1'b1;
      best_r      <= cmp_dist_r;
      win_label_r <= label_rd_r;
    end
  end

  // Output register
  logic               out_valid_r;
  logic               out_found_r;
  logic [LABEL_W-1:0] out_label_r;
  logic [DIST_W-1:0]  out_dist_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.publish) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      out_found_r <= found_r;
      out_label_r <= win_label_r;
      out_dist_r  <= best_r;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_match_found      = out_found_r;
  assign out_best_label       = out_label_r;
  assign out_best_distance_sq = out_dist_r;

  assign status.issue_last = table_empty || (e_r == last_e && c_wrap);
  assign status.pipe_busy  = v1_r || v2_r || v3_r || fin_v_r || cmp_v_r;
  assign status.out_held   = out_valid_r && out_stall;

endmodule

### rtl/nearest_neighbour_l2_classifier_top.sv
// Top level of the nearest-neighbor squared-L2 classifier.
//
// Load transfers (func 0) and query transfers that are not last are taken one per
// cycle while the input is open. A query transfer with query_last set starts a
// scan of every entry in use, one component a cycle, set by the single read port of
// the reference weight memory feeding a difference/square/accumulate/compare
// pipeline. The input then stalls for the whole scan and pipeline drain, plus every
// cycle that the previous result still waits stalled in the output register. The
// result is loaded into the output register on the cycle the input opens again.
// Distances are raw squared Q20.4 differences (units of 2^-8), saturating at all
// ones; an empty table reports no match, label 0, all-ones distance.
module nearest_neighbour_l2_classifier_top
  import nnl2_pkg::*;
#(
  parameter int MAX_ENTRIES    = 256,
  parameter int MAX_COMPONENTS = 64
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       in_func,
  input  logic [7:0]                 in_entry_index,
  input  logic [5:0]                 in_component_index,
  input  logic signed [WEIGHT_W-1:0] in_weight_value,
  input  logic [LABEL_W-1:0]         in_entry_label,
  input  logic                       in_query_last,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       out_match_found,
  output logic [LABEL_W-1:0]         out_best_label,
  output logic [DIST_W-1:0]          out_best_distance_sq,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_DATA_W-1:0]      cfg_data
);

  nnl2_cmd_t    cmd;
  nnl2_status_t status;

  // Register writes are always taken
  assign cfg_ready = 1'b1;

  nnl2_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_func       (in_func),
    .in_query_last (in_query_last),
    .in_stall      (in_stall),
    .status        (status),
    .cmd           (cmd)
  );

  nnl2_datapath #(
    .MAX_ENTRIES    (MAX_ENTRIES),
    .MAX_COMPONENTS (MAX_COMPONENTS)
  ) u_datapath (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_func              (in_func),
    .in_entry_index       (in_entry_index),
    .in_component_index   (in_component_index),
    .in_weight_value      (in_weight_value),
    .in_entry_label       (in_entry_label),
    .cfg_wr               (cfg_valid && cfg_ready),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data),
    .cmd                  (cmd),
    .status               (status),
    .out_stall            (out_stall),
    .out_valid            (out_valid),
    .out_match_found      (out_match_found),
    .out_best_label       (out_best_label),
    .out_best_distance_sq (out_best_distance_sq)
  );

endmodule

### rtl/nnl2_checker.sv
// Port-level checks for the classifier top level, with the bind that attaches them.
module nnl2_checker
  import nnl2_pkg::*;
(
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_stall,
  input logic                       in_func,
  input logic                       in_query_last,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic                       out_match_found,
  input logic [LABEL_W-1:0]         out_best_label,
  input logic [DIST_W-1:0]          out_best_distance_sq
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_best_distance_sq)
      && $stable(out_best_label))
    else $error("stalled result changed or dropped");

  // No match reports label zero and all-ones distance
  a_no_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_match_found |-> out_best_label == '0
      && out_best_distance_sq == DIST_MAX)
    else $error("empty-table result malformed");

  // Loads and non-final query components leave the input open
  a_stream: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && !(in_func == FUNC_QUERY && in_query_last) |=> !in_stall)
    else $error("input closed after a streaming transfer");

  // A final query component closes the input for the scan
  a_scan: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_func == FUNC_QUERY && in_query_last |=> in_stall)
    else $error("input open during search");

endmodule

bind nearest_neighbour_l2_classifier_top nnl2_checker u_nnl2_checker (.*);
